// File: design/fmpf_pkg.sv
package fmpf_pkg;
   localparam int MaxRules = 32;
   localparam int NumHooks = 5;
   localparam int IdxW = $clog2(MaxRules);
   localparam int CntW = $clog2(MaxRules + 1);

   localparam logic [1:0] OP_CLASSIFY = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_FLUSH = 2'd3;

   localparam logic [1:0] TGT_ACCEPT = 2'd0;
   localparam logic [1:0] TGT_DROP = 2'd1;
   localparam logic [1:0] TGT_REJECT = 2'd2;
   localparam logic [1:0] TGT_NAT = 2'd3;

   localparam logic [7:0] PROTO_ICMP = 8'd1;

   typedef struct packed {
      logic [31:0] src;
      logic [31:0] smask;
      logic [31:0] dst;
      logic [31:0] dmask;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [2:0]  hook;
      logic [3:0]  indev;
      logic [3:0]  outdev;
      logic [7:0]  proto;
      logic [1:0]  target;
   } rule_type;

   // controller to datapath
   typedef struct packed {
      logic          load;    // capture item
      logic          write;   // write held rule at count
      logic          shift;   // move entry ptr+1 to ptr
      logic          step;    // examine entry ptr
      logic          dec;
      logic          flush;
      logic [IdxW-1:0] ptr;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [CntW-1:0] count;
      logic [1:0]      op;
      logic            hook_ok;
      logic            app_ok;
      logic            del_ok;
      logic [IdxW-1:0] del_idx;
      logic            hit_final;  // examined rule decides
   } stat_type;
endpackage

// File: design/fmpf_datapath.sv
module fmpf_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  fmpf_pkg::cmd_type    cmd,
   output fmpf_pkg::stat_type   stat,
   input  logic [1:0]           req_op,
   input  logic [2:0]           req_hook,
   input  logic [3:0]           req_in_device,
   input  logic [3:0]           req_out_device,
   input  logic [7:0]           req_protocol,
   input  logic [31:0]          req_src_address,
   input  logic [31:0]          req_dst_address,
   input  logic [31:0]          req_src_mask,
   input  logic [31:0]          req_dst_mask,
   input  logic [15:0]          req_src_port,
   input  logic [15:0]          req_dst_port,
   input  logic [5:0]           req_aux,
   output logic [1:0]           verdict,
   output logic                 send_reject
);
   fmpf_pkg::rule_type mem [fmpf_pkg::MaxRules];
   fmpf_pkg::rule_type item_ff, rd_ff;
   logic [1:0] op_ff;
   logic [5:0] aux_ff;
   logic [fmpf_pkg::CntW-1:0] count_ff, count_in;
   logic [1:0] verdict_ff, verdict_in;
   logic reject_ff, reject_in;
   logic hit;

   // registered read of the entry at the pointer
   always_ff @(posedge clock) begin
      rd_ff <= mem[cmd.ptr];
      if (cmd.write) begin
         mem[count_ff[fmpf_pkg::IdxW-1:0]] <= item_ff;
      end else if (cmd.shift) begin
         mem[cmd.ptr] <= rd_ff;
      end
   end

   function automatic logic dev_ok(input logic [3:0] want, input logic [3:0] dev);
      dev_ok = (want == 4'd0) || (dev != 4'd0 && want == dev);
   endfunction

   always_comb begin
      hit = (rd_ff.hook == item_ff.hook)
         && dev_ok(rd_ff.indev, item_ff.indev)
         && dev_ok(rd_ff.outdev, item_ff.outdev)
         && (rd_ff.proto == 8'd0 || rd_ff.proto == item_ff.proto)
         && ((item_ff.src & rd_ff.smask) == (rd_ff.src & rd_ff.smask))
         && ((item_ff.dst & rd_ff.dmask) == (rd_ff.dst & rd_ff.dmask))
         && (rd_ff.sport == 16'd0 || rd_ff.sport == item_ff.sport)
         && (rd_ff.dport == 16'd0 || rd_ff.dport == item_ff.dport);
   end

   always_comb begin
      verdict_in = verdict_ff;
      reject_in = reject_ff;
      count_in = count_ff;
      if (cmd.load) begin
         verdict_in = fmpf_pkg::TGT_ACCEPT;
         reject_in = 1'b0;
      end else if (cmd.step && hit) begin
         verdict_in = rd_ff.target;
         if (rd_ff.target == fmpf_pkg::TGT_REJECT) begin
            verdict_in = fmpf_pkg::TGT_DROP;
            reject_in = (item_ff.proto != fmpf_pkg::PROTO_ICMP);
         end
      end
      if (cmd.flush) begin
         count_in = '0;
      end else if (cmd.write) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.dec) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         verdict_ff <= fmpf_pkg::TGT_ACCEPT;
         reject_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         verdict_ff <= verdict_in;
         reject_ff <= reject_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_op;
         aux_ff <= req_aux;
         item_ff <= '{src: req_src_address, smask: req_src_mask,
                      dst: req_dst_address, dmask: req_dst_mask,
                      sport: req_src_port, dport: req_dst_port,
                      hook: req_hook, indev: req_in_device,
                      outdev: req_out_device, proto: req_protocol,
                      target: req_aux[1:0]};
      end
   end

   always_comb begin
      stat.count = count_ff;
      stat.op = op_ff;
      stat.hook_ok = ({1'b0, item_ff.hook} < 4'(fmpf_pkg::NumHooks));
      stat.app_ok = (count_ff < fmpf_pkg::CntW'(fmpf_pkg::MaxRules))
         && stat.hook_ok && (aux_ff[5:2] == 4'd0);
      stat.del_ok = ({1'b0, aux_ff} < 7'(count_ff));
      stat.del_idx = aux_ff[fmpf_pkg::IdxW-1:0];
      stat.hit_final = hit && (rd_ff.target != fmpf_pkg::TGT_NAT);
   end

   assign verdict = verdict_ff;
   assign send_reject = reject_ff;

   a_reject_drop: assert property (@(posedge clock) disable iff (reset)
      reject_ff |-> verdict_ff == fmpf_pkg::TGT_DROP) else $error("reject without drop");
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= fmpf_pkg::CntW'(fmpf_pkg::MaxRules)) else $error("count overflow");
   a_write_room: assert property (@(posedge clock) disable iff (reset)
      cmd.write |=> count_ff == $past(count_ff) + 1'b1) else $error("append count");
   a_step_once: assert property (@(posedge clock) disable iff (reset)
      !(cmd.write && cmd.shift)) else $error("write and shift together");
endmodule

// File: design/fmpf_ctrl.sv
module fmpf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_status,
   input  fmpf_pkg::stat_type stat,
   output fmpf_pkg::cmd_type  cmd
);
   typedef enum logic [2:0] {
      IDLE, DECODE, READ, CHECK, SHIFT, RESP
   } state_type;

   state_type state_ff;
   logic [fmpf_pkg::IdxW-1:0] ptr_ff;
   logic status_ff;

   logic last;
   assign last = ({1'b0, ptr_ff} + 1'b1) >= {1'b0, stat.count};

   assign req_ready = (state_ff == IDLE) || (state_ff == RESP && rsp_ready);
   assign rsp_valid = (state_ff == RESP);
   assign rsp_status = status_ff;

   always_comb begin
      cmd = '0;
      cmd.ptr = ptr_ff;
      cmd.load = req_valid && req_ready;
      case (state_ff)
         DECODE: begin
            if (stat.op == fmpf_pkg::OP_APPEND && stat.app_ok) cmd.write = 1'b1;
            if (stat.op == fmpf_pkg::OP_FLUSH) cmd.flush = 1'b1;
         end
         READ: begin
            if (stat.op == fmpf_pkg::OP_DELETE) cmd.ptr = ptr_ff + 1'b1;
         end
         CHECK: cmd.step = 1'b1;
         SHIFT: begin
            cmd.shift = !last;
            cmd.dec = last;
         end
         default: ;
      endcase
   end

   // read issued in READ (ptr, or ptr+1 for delete); data valid in CHECK/SHIFT
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         ptr_ff <= '0;
         status_ff <= 1'b0;
      end else begin
         case (state_ff)
            IDLE: if (req_valid) state_ff <= DECODE;
            DECODE: begin
               case (stat.op)
                  fmpf_pkg::OP_CLASSIFY: begin
                     status_ff <= 1'b0;
                     ptr_ff <= '0;
                     state_ff <= (stat.hook_ok && stat.count != '0) ? READ : RESP;
                  end
                  fmpf_pkg::OP_APPEND: begin
                     status_ff <= !stat.app_ok;
                     state_ff <= RESP;
                  end
                  fmpf_pkg::OP_DELETE: begin
                     status_ff <= !stat.del_ok;
                     ptr_ff <= stat.del_idx;
                     state_ff <= stat.del_ok ? READ : RESP;
                  end
                  default: begin
                     status_ff <= 1'b0;
                     state_ff <= RESP;
                  end
               endcase
            end
            READ: state_ff <= (stat.op == fmpf_pkg::OP_DELETE) ? SHIFT : CHECK;
            CHECK: begin
               if (stat.hit_final || last) begin
                  state_ff <= RESP;
               end else begin
                  ptr_ff <= ptr_ff + 1'b1;
                  state_ff <= READ;
               end
            end
            SHIFT: begin
               if (last) begin
                  state_ff <= RESP;
               end else begin
                  ptr_ff <= ptr_ff + 1'b1;
                  state_ff <= READ;
               end
            end
            RESP: if (rsp_ready) state_ff <= req_valid ? DECODE : IDLE;
            default: state_ff <= IDLE;
         endcase
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (cmd.step || cmd.shift) |-> !req_ready) else $error("busy but ready");
   a_write_decode: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> state_ff == DECODE) else $error("stray write");
endmodule

// File: design/first_match_packet_filter.sv
// first-match packet filter: ordered table of up to 32 rules
// req channel carries one operation per item: classify, append, delete, flush
// rsp channel returns one item per request: status, verdict, send_reject and
// the rule count after the operation
// append and flush go from DECODE straight to RESP; classify examines the
// rules in order, one READ and CHECK per rule, stopping at the first deciding rule;
// delete of entry i moves each later entry up one place, one READ and SHIFT each
// the rule table has one registered read port and one write port; each entry is
// read in READ and used in CHECK or SHIFT, which sets the classify and delete time
// a new item is taken in the cycle its predecessor's result is taken
// reset clears the rule count; the table contents need no clearing
// while rsp_ready is low the result is held and no new item is taken
module first_match_packet_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [2:0]  req_hook,
   input  logic [3:0]  req_in_device,
   input  logic [3:0]  req_out_device,
   input  logic [7:0]  req_protocol,
   input  logic [31:0] req_src_address,
   input  logic [31:0] req_dst_address,
   input  logic [31:0] req_src_mask,
   input  logic [31:0] req_dst_mask,
   input  logic [15:0] req_src_port,
   input  logic [15:0] req_dst_port,
   input  logic [5:0]  req_aux,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [1:0]  rsp_verdict,
   output logic        rsp_send_reject,
   output logic [5:0]  rsp_rule_count
);
   fmpf_pkg::cmd_type  cmd;
   fmpf_pkg::stat_type stat;
   logic [1:0] verdict;
   logic send_reject;

   fmpf_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .rsp_status, .stat, .cmd
   );

   fmpf_datapath u_dp (
      .clock, .reset, .cmd, .stat,
      .req_op, .req_hook, .req_in_device, .req_out_device, .req_protocol,
      .req_src_address, .req_dst_address, .req_src_mask, .req_dst_mask,
      .req_src_port, .req_dst_port, .req_aux,
      .verdict, .send_reject
   );

   // non-classify operations report accept and no reject
   assign rsp_verdict = (stat.op == fmpf_pkg::OP_CLASSIFY) ? verdict : fmpf_pkg::TGT_ACCEPT;
   assign rsp_send_reject = (stat.op == fmpf_pkg::OP_CLASSIFY) && send_reject;
   assign rsp_rule_count = 6'(stat.count);
endmodule
